[src/lpd_pkg.sv]
// Shared types and constants for the lidar packet deframer with CRC-8 check.
// No dependencies; lpd_crc_unit, the top level and lpd_checker import this package.
package lpd_pkg;

    // Field widths
    localparam int DATA_W  = 8;   // received byte and frame byte
    localparam int POS_W   = 6;   // byte position in a frame
    localparam int PPF_W   = 5;   // point count compared against the length byte
    localparam int CFG_IDX_W = 2;

    // Reset values of the configuration registers
    localparam logic [DATA_W-1:0] HEADER_RESET = 8'h54;
    localparam logic [PPF_W-1:0]  PPF_RESET    = 5'd12;
    localparam logic [DATA_W-1:0] POLY_RESET   = 8'h4D;

    // Default frame size, header byte included
    localparam int FRAME_BYTES_DEF = 47;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POINTS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POLY   = 2'd2;

    // Result kinds carried on tuser
    localparam logic KIND_FRAME = 1'b0;
    localparam logic KIND_ERROR = 1'b1;

    // Request to the bit-serial CRC unit
    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] seed;   // running CRC already xored with the new byte
    } t_crc_ctl;

    // Status back from the CRC unit
    typedef struct packed {
        logic              busy;
        logic [DATA_W-1:0] value;  // running CRC, valid while not busy
    } t_crc_stat;

endpackage

[src/lpd_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing; used for the frame store.
module lpd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 47,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[src/lpd_crc_unit.sv]
// Bit-serial MSB-first CRC-8 engine: one shift/xor step per cycle, one step per bit of the byte.
// Depends on lpd_pkg for the request and status structs.
module lpd_crc_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [lpd_pkg::DATA_W-1:0] i_poly,
    input  lpd_pkg::t_crc_ctl          i_ctl,
    output lpd_pkg::t_crc_stat         o_stat
);
    import lpd_pkg::*;

    logic [DATA_W-1:0] r_crc;
    logic [2:0]        r_cnt;
    logic              r_busy;
    logic [DATA_W-1:0] n_crc;

    // One polynomial division step
    always_comb begin
        n_crc = {r_crc[DATA_W-2:0], 1'b0} ^ (r_crc[DATA_W-1] ? i_poly : '0);
    end

    // Step sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc  <= '0;
            r_cnt  <= '0;
            r_busy <= 1'b0;
        end else if (i_ctl.start) begin
            r_crc  <= i_ctl.seed;
            r_cnt  <= '0;
            r_busy <= 1'b1;
        end else if (r_busy) begin
            r_crc <= n_crc;
            r_cnt <= r_cnt + 3'd1;
            if (r_cnt == 3'(DATA_W - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_stat.busy  = r_busy;
    assign o_stat.value = r_crc;

endmodule

[src/lidar_packet_deframer_crc8_top.sv]
// Lidar packet deframer: header/length hunt, frame store, CRC-8 check, replay.
// Depends on lpd_pkg, lpd_crc_unit and lpd_ram.
//
// Bytes enter on the s_axis side one per request. A byte that starts a frame, is
// taken as the length byte or is a payload byte runs through the shared
// bit-serial CRC-8 unit, and s_axis_tready stays low until that unit is done;
// a byte ignored while hunting, or one that drops a half-started frame, is
// taken with no wait. The final byte of a frame is compared with the running
// CRC: on a match the stored frame is replayed from the frame store, each byte
// by a registered RAM read and then an output load, FRAME_BYTES results with
// tlast on the final one; on a mismatch one error result (tuser = 1, tdata = 0,
// tlast = 1) is sent. Output stalls hold replay in its load step. A new byte may
// be taken while the last result still waits on the m_axis side. Configuration
// writes are always taken (o_cfg_ready stays high); unknown indexes are ignored.
// The frame store is not cleared at reset; every entry is written before it is read.
module lidar_packet_deframer_crc8_top #(
    parameter int FRAME_BYTES = lpd_pkg::FRAME_BYTES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input bytes
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [7:0]                    s_axis_tdata,   // [7:0] rx_byte
    // results
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [15:0]                   m_axis_tdata,   // [7:0] frame_byte, [13:8] byte_position
    output logic                          m_axis_tlast,   // last_of_run
    output logic                          m_axis_tuser,   // [0] result_kind
    // configuration writes
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [lpd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]                    i_cfg_data
);
    import lpd_pkg::*;

    localparam int AW = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
    localparam logic [AW-1:0] LAST_IDX = AW'(FRAME_BYTES - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CRC,
        ST_READ,
        ST_LOAD,
        ST_ERROR
    } t_state;

    t_state r_state;

    // configuration
    logic [DATA_W-1:0] r_header;
    logic [PPF_W-1:0]  r_points;
    logic [DATA_W-1:0] r_poly;

    // frame tracking
    logic              r_hdr_seen;
    logic              r_len_seen;
    logic [AW-1:0]     r_fill;
    logic [AW-1:0]     r_idx;

    // output register
    logic              r_out_valid;
    logic [DATA_W-1:0] r_out_byte;
    logic [POS_W-1:0]  r_out_pos;
    logic              r_out_last;
    logic              r_out_kind;

    t_crc_ctl          crc_ctl;
    t_crc_stat         crc_stat;
    logic [DATA_W-1:0] ram_rdata;

    logic in_req, is_hdr, len_ok, at_last, slot_free, out_load;
    logic act_start, act_len, act_drop, act_pay, act_fin;
    logic ram_we;
    logic [AW-1:0] ram_waddr;

    // Decode what an accepted byte does
    always_comb begin
        in_req    = s_axis_tvalid && s_axis_tready;
        is_hdr    = (s_axis_tdata == r_header);
        len_ok    = (s_axis_tdata[PPF_W-1:0] == r_points);
        at_last   = (r_fill == LAST_IDX);
        act_start = in_req && (r_hdr_seen ? (!r_len_seen && !len_ok && is_hdr) : is_hdr);
        act_len   = in_req && r_hdr_seen && !r_len_seen && len_ok;
        act_drop  = in_req && r_hdr_seen && !r_len_seen && !len_ok && !is_hdr;
        act_pay   = in_req && r_hdr_seen && r_len_seen && !at_last;
        act_fin   = in_req && r_hdr_seen && r_len_seen && at_last;
        slot_free = !r_out_valid || m_axis_tready;
        out_load  = ((r_state == ST_LOAD) || (r_state == ST_ERROR)) && slot_free;
    end

    // Frame store write and CRC request
    always_comb begin
        ram_we        = act_start || act_len || act_pay || act_fin;
        ram_waddr     = act_start ? '0 : r_fill;
        crc_ctl.start = act_start || act_len || act_pay;
        crc_ctl.seed  = (act_start ? '0 : crc_stat.value) ^ s_axis_tdata;
    end

    // Sequencer, frame state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_header    <= HEADER_RESET;
            r_points    <= PPF_RESET;
            r_poly      <= POLY_RESET;
            r_hdr_seen  <= 1'b0;
            r_len_seen  <= 1'b0;
            r_fill      <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // configuration writes
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_HEADER: r_header <= i_cfg_data;
                    CFG_POINTS: r_points <= i_cfg_data[PPF_W-1:0];
                    CFG_POLY:   r_poly   <= i_cfg_data;
                    default: ;
                endcase
            end

            // result taken and nothing new loaded this cycle
            if (r_out_valid && m_axis_tready && !out_load) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (act_start) begin
                        r_hdr_seen <= 1'b1;
                        r_len_seen <= 1'b0;
                        r_fill     <= AW'(1);
                        r_state    <= ST_CRC;
                    end else if (act_len) begin
                        r_len_seen <= 1'b1;
                        r_fill     <= r_fill + AW'(1);
                        r_state    <= ST_CRC;
                    end else if (act_pay) begin
                        r_fill     <= r_fill + AW'(1);
                        r_state    <= ST_CRC;
                    end else if (act_drop) begin
                        r_hdr_seen <= 1'b0;
                    end else if (act_fin) begin
                        r_hdr_seen <= 1'b0;
                        r_len_seen <= 1'b0;
                        r_fill     <= '0;
                        r_idx      <= '0;
                        r_state    <= (s_axis_tdata == crc_stat.value) ? ST_READ : ST_ERROR;
                    end
                end
                ST_CRC: begin
                    if (!crc_stat.busy) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_READ: begin
                    r_state <= ST_LOAD;
                end
                ST_LOAD: begin
                    if (slot_free) begin
                        r_out_valid <= 1'b1;
                        r_out_byte  <= ram_rdata;
                        r_out_pos   <= POS_W'(r_idx);
                        r_out_last  <= (r_idx == LAST_IDX);
                        r_out_kind  <= KIND_FRAME;
                        if (r_idx == LAST_IDX) begin
                            r_state <= ST_IDLE;
                        end else begin
                            r_idx   <= r_idx + AW'(1);
                            r_state <= ST_READ;
                        end
                    end
                end
                ST_ERROR: begin
                    if (slot_free) begin
                        r_out_valid <= 1'b1;
                        r_out_byte  <= '0;
                        r_out_pos   <= '0;
                        r_out_last  <= 1'b1;
                        r_out_kind  <= KIND_ERROR;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    lpd_crc_unit u_crc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_poly  (r_poly),
        .i_ctl   (crc_ctl),
        .o_stat  (crc_stat)
    );

    lpd_ram #(
        .WIDTH (DATA_W),
        .DEPTH (FRAME_BYTES),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (s_axis_tdata),
        .i_re    (r_state == ST_READ),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    assign s_axis_tready = (r_state == ST_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out_pos, r_out_byte};
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tuser  = r_out_kind;

endmodule

[src/lpd_checker.sv]
// Port-level assertions for the lidar deframer, bound to the top level.
// Depends on lpd_pkg and lidar_packet_deframer_crc8_top.
module lpd_checker #(
    parameter int FRAME_BYTES = lpd_pkg::FRAME_BYTES_DEF
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic        m_axis_tlast,
    input logic        m_axis_tuser
);
    import lpd_pkg::*;

    localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_BYTES - 1);

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tlast) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // Error result is a single zeroed request closing its run
    a_err_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == KIND_ERROR) |->
            m_axis_tlast && (m_axis_tdata == 16'h0000))
        else $error("malformed error result");

    // Frame bytes end exactly at the last position
    a_frame_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == KIND_FRAME) |->
            (m_axis_tlast == (m_axis_tdata[13:8] == LAST_POS)))
        else $error("tlast not on final frame byte");

endmodule

bind lidar_packet_deframer_crc8_top lpd_checker #(
    .FRAME_BYTES (FRAME_BYTES)
) u_lpd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);
